@@ rtl/dhwc_pkg.sv @@
package dhwc_pkg;

    localparam int NSTG          = 7;
    localparam int HOLIDAY_SLOTS = 14;
    localparam int SLOT_W        = 9;
    localparam int HOL_W         = 63;
    localparam int CFG_IDX_W     = 1;
    localparam int CFG_DATA_W    = 63;

    localparam logic [CFG_IDX_W-1:0] CFG_HOL_A = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HOL_B = 1'd1;

    localparam logic [3:0] CODE_HOLIDAY = 4'd8;

    localparam logic [12:0] DIV100_MUL = 13'd5243;
    localparam logic [15:0] DIV19_MUL  = 16'd55189;
    localparam logic [13:0] DIV7_MUL   = 14'd9363;
    localparam logic [10:0] DIV30_MUL  = 11'd1093;
    localparam logic [5:0]  DIV7S_MUL  = 6'd37;
    localparam logic [5:0]  DIV3_MUL   = 6'd43;

    typedef struct packed {
        logic [4:0]  day_in;
        logic [3:0]  month_in;
        logic [11:0] year_in;
    } t_in_beat;

    typedef struct packed {
        logic [3:0] class_code;
        logic [8:0] ordinal_day;
    } t_out_beat;

    typedef struct packed {
        logic [NSTG-1:0] adv;
    } t_pipe_ctl;

    typedef struct packed {
        logic                  we;
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_DATA_W-1:0] wdata;
    } t_cfg_wr;

    function automatic logic [8:0] cum_days(input logic [3:0] month);
        logic [8:0] v;
        case (month)
            4'd0:    v = 9'd0;
            4'd1:    v = 9'd0;
            4'd2:    v = 9'd31;
            4'd3:    v = 9'd59;
            4'd4:    v = 9'd90;
            4'd5:    v = 9'd120;
            4'd6:    v = 9'd151;
            4'd7:    v = 9'd181;
            4'd8:    v = 9'd212;
            4'd9:    v = 9'd243;
            4'd10:   v = 9'd273;
            4'd11:   v = 9'd304;
            4'd12:   v = 9'd334;
            4'd13:   v = 9'd365;
            4'd14:   v = 9'd396;
            default: v = 9'd427;
        endcase
        return v;
    endfunction

    function automatic logic [5:0] month_term(input logic [3:0] month);
        logic [5:0] v;
        case (month)
            4'd0:    v = 6'd25;
            4'd1:    v = 6'd28;
            4'd2:    v = 6'd31;
            4'd3:    v = 6'd2;
            4'd4:    v = 6'd5;
            4'd5:    v = 6'd7;
            4'd6:    v = 6'd10;
            4'd7:    v = 6'd12;
            4'd8:    v = 6'd15;
            4'd9:    v = 6'd18;
            4'd10:   v = 6'd20;
            4'd11:   v = 6'd23;
            4'd12:   v = 6'd25;
            4'd13:   v = 6'd28;
            4'd14:   v = 6'd31;
            default: v = 6'd33;
        endcase
        return v;
    endfunction

endpackage

@@ rtl/dhwc_ctrl.sv @@
module dhwc_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  logic                 i_stall,
    output logic                 o_stall,
    output logic                 o_valid,
    output dhwc_pkg::t_pipe_ctl  o_ctl
);

    logic [dhwc_pkg::NSTG-1:0] r_vld;
    logic [dhwc_pkg::NSTG-1:0] n_vld;
    logic [dhwc_pkg::NSTG-1:0] w_adv;

    always_comb begin
        w_adv[dhwc_pkg::NSTG-1] = !r_vld[dhwc_pkg::NSTG-1] || !i_stall;
        for (int k = dhwc_pkg::NSTG - 2; k >= 0; k--) begin
            w_adv[k] = !r_vld[k] || w_adv[k+1];
        end
    end

    always_comb begin
        n_vld = r_vld;
        if (w_adv[0]) begin
            n_vld[0] = i_valid;
        end
        for (int k = 1; k < dhwc_pkg::NSTG; k++) begin
            if (w_adv[k]) begin
                n_vld[k] = r_vld[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    assign o_ctl.adv = w_adv;
    assign o_stall   = !w_adv[0];
    assign o_valid   = r_vld[dhwc_pkg::NSTG-1];

endmodule

@@ rtl/dhwc_easter.sv @@
module dhwc_easter (
    input  logic                 i_clk,
    input  dhwc_pkg::t_pipe_ctl  i_ctl,
    input  logic [11:0]          i_year,
    output logic                 o_leap,
    output logic [6:0]           o_east
);

    // stage 1
    logic [24:0] w_cent_prod;
    logic [27:0] w_q19_prod;
    logic [11:0] r1_year;
    logic [5:0]  r1_cent;
    logic [7:0]  r1_q19;

    assign w_cent_prod = 25'(i_year) * 25'(dhwc_pkg::DIV100_MUL);
    assign w_q19_prod  = 28'(i_year) * 28'(dhwc_pkg::DIV19_MUL);

    always_ff @(posedge i_clk) begin
        if (i_ctl.adv[0]) begin
            r1_year <= i_year;
            r1_cent <= w_cent_prod[24:19];
            r1_q19  <= w_q19_prod[27:20];
        end
    end

    // stage 2
    logic [11:0] w_a_diff;
    logic [11:0] w_yc_diff;
    logic [5:0]  w_gx;
    logic [11:0] w_g_prod;
    logic [4:0]  r2_a;
    logic [6:0]  r2_yc;
    logic [5:0]  r2_cent;
    logic [3:0]  r2_g;
    logic        r2_leap;

    assign w_a_diff  = r1_year - 12'(r1_q19 * 12'd19);
    assign w_yc_diff = r1_year - 12'(r1_cent * 12'd100);
    assign w_gx      = r1_cent + 6'd1 - ((r1_cent >= 6'd17) ? 6'd1 : 6'd0);
    assign w_g_prod  = 12'(w_gx) * 12'(dhwc_pkg::DIV3_MUL);

    always_ff @(posedge i_clk) begin
        if (i_ctl.adv[1]) begin
            r2_a    <= w_a_diff[4:0];
            r2_yc   <= w_yc_diff[6:0];
            r2_cent <= r1_cent;
            r2_g    <= w_g_prod[10:7];
            r2_leap <= (w_yc_diff[6:0] == 7'd0) ? (r1_cent[1:0] == 2'd0)
                                                : (r1_year[1:0] == 2'd0);
        end
    end

    assign o_leap = r2_leap;

    // stage 3
    logic [8:0] r3_hsum;
    logic [6:0] r3_t;
    logic [4:0] r3_a;
    logic       r3_leap;

    always_ff @(posedge i_clk) begin
        if (i_ctl.adv[2]) begin
            r3_hsum <= 9'(r2_a * 9'd19) + 9'(r2_cent) - 9'(r2_cent[5:2]) - 9'(r2_g)
                       + 9'd15;
            r3_t    <= 7'd32 + 7'({r2_cent[1:0], 1'b0}) + 7'({r2_yc[6:2], 1'b0})
                       - 7'(r2_yc[1:0]);
            r3_a    <= r2_a;
            r3_leap <= r2_leap;
        end
    end

    // stage 4
    logic [18:0] w_q30_prod;
    logic [8:0]  w_h_diff;
    logic [4:0]  r4_h;
    logic [6:0]  r4_t;
    logic [4:0]  r4_a;
    logic        r4_leap;

    assign w_q30_prod = 19'(r3_hsum) * 19'(dhwc_pkg::DIV30_MUL);
    assign w_h_diff   = r3_hsum - 9'(w_q30_prod[18:15] * 9'd30);

    always_ff @(posedge i_clk) begin
        if (i_ctl.adv[3]) begin
            r4_h    <= w_h_diff[4:0];
            r4_t    <= r3_t;
            r4_a    <= r3_a;
            r4_leap <= r3_leap;
        end
    end

    // stage 5
    logic [6:0]  w_lx;
    logic [11:0] w_q7_prod;
    logic [6:0]  w_l_diff;
    logic [2:0]  r5_l;
    logic [4:0]  r5_h;
    logic [4:0]  r5_a;
    logic        r5_leap;

    assign w_lx      = r4_t - 7'(r4_h);
    assign w_q7_prod = 12'(w_lx) * 12'(dhwc_pkg::DIV7S_MUL);
    assign w_l_diff  = w_lx - 7'(w_q7_prod[11:8] * 7'd7);

    always_ff @(posedge i_clk) begin
        if (i_ctl.adv[4]) begin
            r5_l    <= w_l_diff[2:0];
            r5_h    <= r4_h;
            r5_a    <= r4_a;
            r5_leap <= r4_leap;
        end
    end

    // stage 6
    logic [8:0] w_msum;
    logic       w_m;
    logic [6:0] r6_east;

    assign w_msum = 9'(r5_a) + 9'(r5_h * 9'd11) + 9'(r5_l * 9'd22);
    assign w_m    = (w_msum >= 9'd451);

    always_ff @(posedge i_clk) begin
        if (i_ctl.adv[5]) begin
            r6_east <= 7'(r5_h) + 7'(r5_l) + 7'd81 + 7'(r5_leap) - (w_m ? 7'd7 : 7'd0);
        end
    end

    assign o_east = r6_east;

endmodule

@@ rtl/dhwc_date.sv @@
module dhwc_date (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  dhwc_pkg::t_pipe_ctl  i_ctl,
    input  dhwc_pkg::t_cfg_wr    i_cfg,
    input  dhwc_pkg::t_in_beat   i_data,
    input  logic                 i_leap,
    output logic [8:0]           o_ord,
    output logic [3:0]           o_wd,
    output logic                 o_fixed
);

    logic [dhwc_pkg::HOL_W-1:0] r_hol_a;
    logic [dhwc_pkg::HOL_W-1:0] r_hol_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hol_a <= '0;
            r_hol_b <= '0;
        end else if (i_cfg.we) begin
            case (i_cfg.idx)
                dhwc_pkg::CFG_HOL_A: r_hol_a <= i_cfg.wdata[dhwc_pkg::HOL_W-1:0];
                dhwc_pkg::CFG_HOL_B: r_hol_b <= i_cfg.wdata[dhwc_pkg::HOL_W-1:0];
                default: ;
            endcase
        end
    end

    // stage 1
    logic [2*dhwc_pkg::HOL_W-1:0] w_tab;
    logic [dhwc_pkg::SLOT_W-1:0]  w_ent;
    logic                         w_hit;
    logic                         w_shift;
    logic [12:0]                  w_wy;
    logic [25:0]                  w_wc_prod;

    assign w_tab = {r_hol_b, r_hol_a};

    always_comb begin
        w_hit = 1'b0;
        w_ent = '0;
        for (int k = 0; k < dhwc_pkg::HOLIDAY_SLOTS; k++) begin
            w_ent = w_tab[k*dhwc_pkg::SLOT_W +: dhwc_pkg::SLOT_W];
            if (w_ent[4:0] != 5'd0 && w_ent[4:0] == i_data.day_in
                && w_ent[8:5] == i_data.month_in) begin
                w_hit = 1'b1;
            end
        end
    end

    assign w_shift   = (i_data.month_in <= 4'd2);
    assign w_wy      = 13'(i_data.year_in) + 13'd400 - 13'(w_shift);
    assign w_wc_prod = 26'(w_wy) * 26'(dhwc_pkg::DIV100_MUL);

    logic [4:0]  r1_day;
    logic [3:0]  r1_month;
    logic        r1_fixed;
    logic [12:0] r1_wy;
    logic [5:0]  r1_wc;

    always_ff @(posedge i_clk) begin
        if (i_ctl.adv[0]) begin
            r1_day   <= i_data.day_in;
            r1_month <= i_data.month_in;
            r1_fixed <= w_hit;
            r1_wy    <= w_wy;
            r1_wc    <= w_wc_prod[24:19];
        end
    end

    // stage 2
    logic [12:0] r2_wsum;
    logic [8:0]  r2_ord;
    logic        r2_late;
    logic        r2_fixed;

    always_ff @(posedge i_clk) begin
        if (i_ctl.adv[1]) begin
            r2_wsum  <= 13'(r1_day) + r1_wy + 13'(r1_wy[12:2]) - 13'(r1_wc)
                        + 13'(r1_wc[5:2]) + 13'(dhwc_pkg::month_term(r1_month));
            r2_ord   <= dhwc_pkg::cum_days(r1_month) + 9'(r1_day);
            r2_late  <= (r1_month >= 4'd3);
            r2_fixed <= r1_fixed;
        end
    end

    // stage 3
    logic [25:0] w_q7_prod;
    logic [12:0] r3_wsum;
    logic [9:0]  r3_q7;
    logic [8:0]  r3_ord;
    logic        r3_fixed;

    assign w_q7_prod = 26'(r2_wsum) * 26'(dhwc_pkg::DIV7_MUL);

    always_ff @(posedge i_clk) begin
        if (i_ctl.adv[2]) begin
            r3_wsum  <= r2_wsum;
            r3_q7    <= w_q7_prod[25:16];
            r3_ord   <= r2_ord + 9'(r2_late & i_leap);
            r3_fixed <= r2_fixed;
        end
    end

    // stage 4
    logic [12:0] w_rem;
    logic [3:0]  r4_wd;
    logic [8:0]  r4_ord;
    logic        r4_fixed;

    assign w_rem = r3_wsum - 13'(r3_q7 * 13'd7);

    always_ff @(posedge i_clk) begin
        if (i_ctl.adv[3]) begin
            r4_wd    <= 4'(w_rem[2:0]) + 4'd1;
            r4_ord   <= r3_ord;
            r4_fixed <= r3_fixed;
        end
    end

    // stages 5 and 6: hold alongside the Easter path
    logic [3:0] r5_wd;
    logic [8:0] r5_ord;
    logic       r5_fixed;
    logic [3:0] r6_wd;
    logic [8:0] r6_ord;
    logic       r6_fixed;

    always_ff @(posedge i_clk) begin
        if (i_ctl.adv[4]) begin
            r5_wd    <= r4_wd;
            r5_ord   <= r4_ord;
            r5_fixed <= r4_fixed;
        end
        if (i_ctl.adv[5]) begin
            r6_wd    <= r5_wd;
            r6_ord   <= r5_ord;
            r6_fixed <= r5_fixed;
        end
    end

    assign o_ord   = r6_ord;
    assign o_wd    = r6_wd;
    assign o_fixed = r6_fixed;

endmodule

@@ rtl/date_holiday_weekday_classifier.sv @@
// Date classifier: holiday flag or weekday, plus day of year.
//
// Input channel: i_valid / o_stall with i_data (day, month, year). A beat is
// taken at a rising edge with i_valid high and o_stall low.
// Output channel: o_valid / i_stall with o_data (class_code, ordinal_day).
// class_code is 8 for a fixed holiday from the table or an Easter-related
// day, else the weekday, 1 for Sunday through 7 for Saturday.
// Configuration: i_cfg_we, i_cfg_idx, i_cfg_wdata write the two holiday
// table words (seven 9-bit day/month slots each, day zero marks a free
// slot). Write them only while no beat is in flight.
// From input beat to output beat there are six datapath stages (division by
// constants as reciprocal multiplies, Easter chain) and one output register.
// Throughput is one beat per cycle while i_stall does not hold the output.
// Reset clears all stage valid bits and both table words; o_valid and
// o_stall are low after reset.
// When i_stall holds an output beat, stages behind it keep filling; o_stall
// rises only once every stage holds a beat.
module date_holiday_weekday_classifier (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_stall,
    input  dhwc_pkg::t_in_beat                 i_data,
    output logic                               o_valid,
    input  logic                               i_stall,
    output dhwc_pkg::t_out_beat                o_data,
    input  logic                               i_cfg_we,
    input  logic [dhwc_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [dhwc_pkg::CFG_DATA_W-1:0]    i_cfg_wdata
);

    dhwc_pkg::t_pipe_ctl w_ctl;
    dhwc_pkg::t_cfg_wr   w_cfg;
    logic                w_leap;
    logic [6:0]          w_east;
    logic [8:0]          w_ord;
    logic [3:0]          w_wd;
    logic                w_fixed;

    assign w_cfg.we    = i_cfg_we;
    assign w_cfg.idx   = i_cfg_idx;
    assign w_cfg.wdata = i_cfg_wdata;

    dhwc_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_stall (i_stall),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .o_ctl   (w_ctl)
    );

    dhwc_easter u_easter (
        .i_clk  (i_clk),
        .i_ctl  (w_ctl),
        .i_year (i_data.year_in),
        .o_leap (w_leap),
        .o_east (w_east)
    );

    dhwc_date u_date (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl),
        .i_cfg   (w_cfg),
        .i_data  (i_data),
        .i_leap  (w_leap),
        .o_ord   (w_ord),
        .o_wd    (w_wd),
        .o_fixed (w_fixed)
    );

    logic [9:0]          w_ord_x;
    logic [9:0]          w_east_x;
    logic                w_easter_hit;
    dhwc_pkg::t_out_beat r_out;

    assign w_ord_x      = 10'(w_ord);
    assign w_east_x     = 10'(w_east);
    assign w_easter_hit = (w_ord_x == w_east_x) || (w_ord_x + 10'd1 == w_east_x)
                          || (w_ord_x + 10'd2 == w_east_x)
                          || (w_ord_x == w_east_x + 10'd60);

    always_ff @(posedge i_clk) begin
        if (w_ctl.adv[dhwc_pkg::NSTG-1]) begin
            r_out.class_code  <= (w_fixed || w_easter_hit) ? dhwc_pkg::CODE_HOLIDAY : w_wd;
            r_out.ordinal_day <= w_ord;
        end
    end

    assign o_data = r_out;

endmodule

@@ rtl/dhwc_checker.sv @@
module dhwc_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                o_stall,
    input logic                o_valid,
    input logic                i_stall,
    input dhwc_pkg::t_out_beat o_data
);

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && !o_stall)
        else $error("outputs active after reset");

    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid && i_stall)
        else $error("input stalled while output side free");

    a_code_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_data.class_code >= 4'd1 && o_data.class_code <= 4'd8)
        else $error("class code out of range");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_data))
        else $error("stalled output beat changed");

endmodule

bind date_holiday_weekday_classifier dhwc_checker u_dhwc_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .o_stall (o_stall),
    .o_valid (o_valid),
    .i_stall (i_stall),
    .o_data  (o_data)
);
